// ===== src/fltpm_pkg.sv =====
// Package for the four-level page table maintainer.
// Holds entry layout constants, request and status codes, and the default pool size.
// No dependencies; every other file in src imports it.
`timescale 1ns / 1ps

package fltpm_pkg;

  // Default number of table frames in the pool.
  localparam int TABLE_FRAMES_DEFAULT = 64;

  // Geometry of one table frame and of the payload fields.
  localparam int IDX_W    = 9;
  localparam int VPAGE_W  = 36;
  localparam int PAGE_W   = 40;
  localparam int FLAGS_W  = 12;
  localparam int ENTRY_W  = 64;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam logic [0:0] REG_TABLE_BASE = 1'b0;

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FLAG  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNMAP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POOL_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEVEL_MISSING  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_MAPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED     = 3'd4;

  // Low bits of a link entry: present and writable.
  localparam logic [FLAGS_W-1:0] LINK_FLAGS = 12'h003;

endpackage

// ===== src/four_level_page_table_maintainer.sv =====
// Four-level page table maintainer over one table memory; uses fltpm_pkg and fltpm_store.
// Each level visited takes a lookup state and an evaluate state; a full walk visits all four
// levels, a failing level ends the walk early, and an unused action is answered without a walk.
// A new request is taken only in idle, after the previous one has finished, since busy stays high
// through the walk over the single memory port, read once at each of the four levels. Reset: a
// clearing pass zeroes the store with busy high; no receiver stall.
`timescale 1ns / 1ps

module four_level_page_table_maintainer #(
  parameter int TABLE_FRAMES = fltpm_pkg::TABLE_FRAMES_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [fltpm_pkg::ACTION_W-1:0]        action,
  input  logic [fltpm_pkg::VPAGE_W-1:0]         virt_page,
  input  logic [fltpm_pkg::PAGE_W-1:0]          phys_page,
  input  logic [fltpm_pkg::FLAGS_W-1:0]         flags_low,
  input  logic                                  no_execute,
  // Result channel
  output logic                                  done,
  output logic [fltpm_pkg::STATUS_W-1:0]        status,
  output logic                                  flush_page,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fltpm_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fltpm_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fltpm_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);
  import fltpm_pkg::*;

  localparam int FRAME_W = $clog2(TABLE_FRAMES);
  localparam int NFF_W   = $clog2(TABLE_FRAMES + 1);
  localparam int AW      = FRAME_W + IDX_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_EVAL   = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [ACTION_W-1:0] action_q;
  logic [VPAGE_W-1:0]  vpage_q;
  logic [PAGE_W-1:0]   phys_q;
  logic [FLAGS_W-1:0]  flags_q;
  logic                nx_q;
  logic [1:0]          level;
  logic [FRAME_W-1:0]  frame;
  logic [NFF_W-1:0]    next_free;
  logic [PAGE_W-1:0]   table_base;

  logic                clearing;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [ENTRY_W-1:0]  mem_rdata;

  logic [IDX_W-1:0]    idx;
  logic [PAGE_W-1:0]   link_rel;
  logic                link_ok;
  logic                pool_empty;
  logic                finish;
  logic                descend;
  logic                alloc;
  logic [STATUS_W-1:0] fin_status;
  logic                fin_flush;
  logic [FRAME_W-1:0]  child;
  logic                accept;

  // Table store with its clearing pass.
  fltpm_store #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .we       (mem_we),
    .addr     (mem_addr),
    .wdata    (mem_wdata),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  // Configuration register access; writes land on the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_TABLE_BASE) ? {{(APB_DATA_W - PAGE_W){1'b0}}, table_base}
                                               : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[3] == REG_TABLE_BASE)) begin
      table_base <= pwdata[PAGE_W-1:0];
    end
  end

  assign busy   = clearing || (state != S_IDLE);
  assign accept = start && !busy;

  // Index slice for the level being walked.
  always_comb begin
    case (level)
      2'd0:    idx = vpage_q[35:27];
      2'd1:    idx = vpage_q[26:18];
      2'd2:    idx = vpage_q[17:9];
      default: idx = vpage_q[8:0];
    endcase
  end

  assign mem_addr   = {frame, idx};
  assign link_rel   = mem_rdata[51:12] - table_base;
  assign link_ok    = link_rel < {{(PAGE_W - NFF_W){1'b0}}, next_free};
  assign pool_empty = (next_free == NFF_W'(TABLE_FRAMES));
  assign alloc      = (action_q == ACT_MAP);

  // Evaluate the entry read back: follow, allocate, or update the leaf.
  always_comb begin
    mem_we     = 1'b0;
    mem_wdata  = '0;
    finish     = 1'b0;
    descend    = 1'b0;
    fin_status = ST_OK;
    fin_flush  = 1'b0;
    child      = link_rel[FRAME_W-1:0];
    if (state == S_EVAL) begin
      if (level != 2'd3) begin
        if (mem_rdata[0]) begin
          if (link_ok) begin
            descend = 1'b1;
          end else begin
            finish     = 1'b1;
            fin_status = ST_LEVEL_MISSING;
          end
        end else if (!alloc) begin
          finish     = 1'b1;
          fin_status = ST_LEVEL_MISSING;
        end else if (pool_empty) begin
          finish     = 1'b1;
          fin_status = ST_POOL_EMPTY;
        end else begin
          // New table frame from the bump pool, linked present and writable.
          descend   = 1'b1;
          child     = next_free[FRAME_W-1:0];
          mem_we    = 1'b1;
          mem_wdata = {12'd0, table_base + {{(PAGE_W - NFF_W){1'b0}}, next_free}, LINK_FLAGS};
        end
      end else begin
        finish = 1'b1;
        case (action_q)
          ACT_MAP: begin
            if (mem_rdata[0]) begin
              fin_status = ST_ALREADY_MAPPED;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {nx_q, 11'd0, phys_q, flags_q};
            end
          end
          ACT_FLAG: begin
            if (!mem_rdata[0]) begin
              fin_status = ST_NOT_MAPPED;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {nx_q, 11'd0, mem_rdata[51:12], flags_q};
              fin_flush = 1'b1;
            end
          end
          default: begin
            if (!mem_rdata[0]) begin
              fin_status = ST_NOT_MAPPED;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '0;
              fin_flush = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (action <= ACT_UNMAP)) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = S_EVAL;
      S_EVAL: begin
        if (finish) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_LOOKUP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers: state, walk position, pool pointer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_free <= NFF_W'(1);
      done      <= 1'b0;
      level     <= 2'd0;
      frame     <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept) begin
        level <= 2'd0;
        frame <= '0;
        if (action > ACT_UNMAP) begin
          done <= 1'b1;
        end
      end else if (descend) begin
        level <= level + 2'd1;
        frame <= child;
      end
      if (finish) begin
        done <= 1'b1;
      end
      if (descend && mem_we) begin
        next_free <= next_free + NFF_W'(1);
      end
    end
  end

  // Request payload and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      action_q   <= action;
      vpage_q    <= virt_page;
      phys_q     <= phys_page;
      flags_q    <= flags_low;
      nx_q       <= no_execute;
      status     <= ST_OK;
      flush_page <= 1'b0;
    end else if (finish) begin
      status     <= fin_status;
      flush_page <= fin_flush;
    end
  end

endmodule

// ===== src/fltpm_store.sv =====
// Table store of the four-level page table maintainer: one synchronous memory of
// 512-entry frames with a clearing pass after reset. Depends on fltpm_pkg.
`timescale 1ns / 1ps

module fltpm_store #(
  parameter int TABLE_FRAMES = fltpm_pkg::TABLE_FRAMES_DEFAULT
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    we,
  input  logic [$clog2(TABLE_FRAMES)+fltpm_pkg::IDX_W-1:0]        addr,
  input  logic [fltpm_pkg::ENTRY_W-1:0]                           wdata,
  output logic [fltpm_pkg::ENTRY_W-1:0]                           rdata,
  output logic                                                    clearing
);
  import fltpm_pkg::*;

  localparam int AW    = $clog2(TABLE_FRAMES) + IDX_W;
  localparam int DEPTH = TABLE_FRAMES * (2 ** IDX_W);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      clear_addr;

  // Clearing pass: walk every entry once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clear_addr <= clear_addr + AW'(1);
    end
  end

  // Single port: one write or the clearing write, and a registered read.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== tb/page_table_monitor.sv =====
// Checker for the four-level page table maintainer: watches the request, result and APB ports.
// It keeps its own copy of the table pool, predicts each result and compares in order.
// Depends on fltpm_pkg.
`timescale 1ns / 1ps

module page_table_monitor #(
  parameter int TABLE_FRAMES = fltpm_pkg::TABLE_FRAMES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [fltpm_pkg::ACTION_W-1:0]   action,
  input  logic [fltpm_pkg::VPAGE_W-1:0]    virt_page,
  input  logic [fltpm_pkg::PAGE_W-1:0]     phys_page,
  input  logic [fltpm_pkg::FLAGS_W-1:0]    flags_low,
  input  logic                             no_execute,
  input  logic                             done,
  input  logic [fltpm_pkg::STATUS_W-1:0]   status,
  input  logic                             flush_page,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [fltpm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fltpm_pkg::APB_DATA_W-1:0] pwdata,
  output int                               error_count,
  output int                               pending_count
);
  import fltpm_pkg::*;

  localparam int ENTRIES_PER_FRAME = 512;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VPAGE_W-1:0]  vpage;
    logic [PAGE_W-1:0]   phys;
    logic [FLAGS_W-1:0]  flags;
    logic                nx;
  } page_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                flush;
  } page_outcome_t;

  // Shadow copy of the table pool and the allocator.
  bit [ENTRY_W-1:0] shadow_tables [TABLE_FRAMES*ENTRIES_PER_FRAME];
  int               next_frame;
  logic [PAGE_W-1:0] base_page;

  page_outcome_t awaited_outcomes [$];
  int            errors = 0;
  int            result_index = 0;

  // Follows the link at (frame, idx), creating the next table when allowed.
  function automatic logic [STATUS_W-1:0] follow_link(input int frame,
                                                     input logic [IDX_W-1:0] idx,
                                                     input bit alloc, output int child);
    int               slot;
    logic [ENTRY_W-1:0] entry;
    logic [PAGE_W-1:0]  rel;
    slot = frame * ENTRIES_PER_FRAME + int'(idx);
    entry = shadow_tables[slot];
    child = 0;
    if (entry[0]) begin
      // A link to a page outside the handed-out part of the pool counts as missing.
      rel = entry[51:12] - base_page;
      if (rel >= PAGE_W'(next_frame)) return ST_LEVEL_MISSING;
      child = int'(rel);
      return ST_OK;
    end
    if (!alloc) return ST_LEVEL_MISSING;
    if (next_frame >= TABLE_FRAMES) return ST_POOL_EMPTY;
    shadow_tables[slot] = {12'h000, base_page + PAGE_W'(next_frame), LINK_FLAGS};
    child = next_frame;
    next_frame++;
    return ST_OK;
  endfunction

  // Walks the four levels for one request and applies its update.
  function automatic page_outcome_t apply_page_request(input page_request_t req);
    page_outcome_t      res;
    logic [IDX_W-1:0]   idx [4];
    int                 frame;
    int                 slot;
    logic [ENTRY_W-1:0] leaf;
    bit                 alloc;
    res.status = ST_OK;
    res.flush = 1'b0;
    idx[0] = req.vpage[35:27];
    idx[1] = req.vpage[26:18];
    idx[2] = req.vpage[17:9];
    idx[3] = req.vpage[8:0];
    if (req.action == ACT_MAP || req.action == ACT_FLAG || req.action == ACT_UNMAP) begin
      alloc = (req.action == ACT_MAP);
      frame = 0;
      for (int lvl = 0; lvl < 3 && res.status == ST_OK; lvl++) begin
        res.status = follow_link(frame, idx[lvl], alloc, frame);
      end
      if (res.status == ST_OK) begin
        slot = frame * ENTRIES_PER_FRAME + int'(idx[3]);
        leaf = shadow_tables[slot];
        if (req.action == ACT_MAP) begin
          if (leaf[0]) res.status = ST_ALREADY_MAPPED;
          else shadow_tables[slot] = {req.nx, 11'h000, req.phys, req.flags};
        end else if (!leaf[0]) begin
          res.status = ST_NOT_MAPPED;
        end else begin
          // Re-flag keeps the page number; unmap clears the whole entry.
          if (req.action == ACT_FLAG)
            shadow_tables[slot] = {req.nx, 11'h000, leaf[51:12], req.flags};
          else shadow_tables[slot] = '0;
          res.flush = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Results are checked before new requests, so a request never meets its own edge.
  always @(posedge clk) begin : observe
    page_request_t req;
    page_outcome_t want;
    if (rst) begin
      foreach (shadow_tables[i]) shadow_tables[i] = '0;
      next_frame = 1;
      base_page = '0;
      awaited_outcomes.delete();
    end else begin
      if (done) begin
        if (awaited_outcomes.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("result %0d arrived with no request outstanding: status %0d flush_page %0b",
                     result_index, status, flush_page);
        end else begin
          want = awaited_outcomes.pop_front();
          if (status !== want.status || flush_page !== want.flush) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"result %0d mismatch: status expected %0d got %0d, ",
                        "flush_page expected %0b got %0b"},
                       result_index, want.status, status, want.flush, flush_page);
          end
        end
        result_index++;
      end
      if (start && !busy) begin
        req = '{action: action, vpage: virt_page, phys: phys_page, flags: flags_low,
                nx: no_execute};
        awaited_outcomes.push_back(apply_page_request(req));
      end
      if (psel && penable && pwrite && pready && paddr[3] == REG_TABLE_BASE)
        base_page = pwdata[PAGE_W-1:0];
    end
    error_count <= errors;
    pending_count <= awaited_outcomes.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the page table maintainer testbench: clock, reset, request and APB stimulus, verdict.
// Prediction and comparison live in page_table_monitor.
// Depends on fltpm_pkg, page_table_monitor and four_level_page_table_maintainer.
`timescale 1ns / 1ps

module tb;
  import fltpm_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // The clearing pass after reset dominates; several times over it.
  localparam int IDLE_LIMIT = 150000;
  localparam int RECENT_DEPTH = 48;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [ACTION_W-1:0]   action;
  logic [VPAGE_W-1:0]    virt_page;
  logic [PAGE_W-1:0]     phys_page;
  logic [FLAGS_W-1:0]    flags_low;
  logic                  no_execute;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic                  flush_page;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int error_count;
  int pending_count;
  int stalled_cycles = 0;
  int quiet_run = 0;

  // Per-level index alphabet, so that random pages share tables.
  logic [IDX_W-1:0]  index_choices [3][4];
  logic [VPAGE_W-1:0] mapped_pages [$];
  logic [PAGE_W-1:0]  wrap_base;

  four_level_page_table_maintainer dut (.*);

  page_table_monitor monitor (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .virt_page(virt_page), .phys_page(phys_page), .flags_low(flags_low),
    .no_execute(no_execute), .done(done), .status(status), .flush_page(flush_page),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .error_count(error_count), .pending_count(pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Issues one request after a random gap and waits until it is accepted.
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [VPAGE_W-1:0] vp,
                              input logic [PAGE_W-1:0] pp, input logic [FLAGS_W-1:0] fl,
                              input logic nx);
    int gap;
    if (quiet_run > 0) begin
      gap = 0;
      quiet_run--;
    end else if ($urandom_range(0, 19) == 0) begin
      gap = 0;
      quiet_run = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 17);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    virt_page <= vp;
    phys_page <= pp;
    flags_low <= fl;
    no_execute <= nx;
    do @(posedge clk); while (busy);
  endtask

  // Writes the table base once every request has been answered.
  task automatic write_table_base(input logic [PAGE_W-1:0] page);
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TABLE_BASE, 3'b000};
    pwdata <= {{(APB_DATA_W-PAGE_W){1'b0}}, page};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // A page drawn from the shared index alphabet; the leaf index is often fully random.
  function automatic logic [VPAGE_W-1:0] tree_page();
    logic [IDX_W-1:0] leaf_idx;
    case ($urandom_range(0, 3))
      0: leaf_idx = '0;
      1: leaf_idx = '1;
      default: leaf_idx = IDX_W'($urandom);
    endcase
    return {index_choices[0][$urandom_range(0, 3)], index_choices[1][$urandom_range(0, 3)],
            index_choices[2][$urandom_range(0, 3)], leaf_idx};
  endfunction

  // Mostly well-formed map, flag and unmap traffic over a small tree, with some noise.
  task automatic send_random_request();
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [VPAGE_W-1:0]  vp;
    logic [PAGE_W-1:0]   pp;
    logic [63:0]         raw;
    pick = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: pp = '0;
      1: pp = '1;
      default: pp = raw[PAGE_W-1:0];
    endcase
    vp = tree_page();
    if (pick < 4) begin
      act = ACTION_W'($urandom_range(0, 3));
      raw = {$urandom, $urandom};
      vp = raw[VPAGE_W-1:0];
    end else if (pick < 8) begin
      act = ACT_UNUSED;
    end else if (pick < 50) begin
      act = ACT_MAP;
      if (mapped_pages.size() > 0 && $urandom_range(0, 3) == 0) begin
        vp = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      end else begin
        mapped_pages.push_back(vp);
        if (mapped_pages.size() > RECENT_DEPTH) void'(mapped_pages.pop_front());
      end
    end else begin
      act = (pick < 75) ? ACT_FLAG : ACT_UNMAP;
      if (mapped_pages.size() > 0 && $urandom_range(0, 9) < 7)
        vp = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
    end
    send_request(act, vp, pp, FLAGS_W'($urandom), 1'($urandom));
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_request();
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    action <= ACT_MAP;
    virt_page <= '0;
    phys_page <= '0;
    flags_low <= '0;
    no_execute <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int l = 0; l < 3; l++) begin
      index_choices[l][0] = '0;
      index_choices[l][1] = '1;
      index_choices[l][2] = IDX_W'($urandom_range(1, 510));
      index_choices[l][3] = IDX_W'($urandom_range(1, 510));
    end
    // A base close to the top so that later frames wrap around to low pages.
    wrap_base = '1 - PAGE_W'($urandom_range(1, 39));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Let the clearing pass finish before touching the register.
    do @(posedge clk); while (busy);
    write_table_base(wrap_base);

    // Directed requests: leaf without present bit, re-map, re-flag, unmap,
    // missing levels, unused action and field extremes.
    send_request(ACT_MAP, '0, '0, 12'h000, 1'b0);
    send_request(ACT_MAP, '0, '1, 12'hfff, 1'b1);
    send_request(ACT_MAP, '0, '1, 12'hfff, 1'b1);
    send_request(ACT_FLAG, '0, '0, 12'h001, 1'b0);
    send_request(ACT_UNMAP, '0, '0, 12'h000, 1'b0);
    send_request(ACT_UNMAP, '0, '0, 12'h000, 1'b0);
    send_request(ACT_FLAG, '0, '0, 12'hfff, 1'b1);
    send_request(ACT_FLAG, '1, '1, 12'hfff, 1'b1);
    send_request(ACT_UNMAP, '1, '1, 12'hfff, 1'b1);
    send_request(ACT_UNUSED, '1, '1, 12'hfff, 1'b1);
    send_request(ACT_MAP, '1, '1, 12'hfff, 1'b1);
    send_request(ACT_FLAG, '1, '0, 12'hffe, 1'b0);
    send_request(ACT_UNMAP, '1, '0, 12'h000, 1'b0);
    send_request(ACT_MAP, {27'h0, 9'h1ff}, 40'h55_5555_5555, 12'haaa, 1'b0);

    // Random phases; each base change reinterprets the links already stored.
    run_random(300);
    write_table_base(wrap_base - 40'd2);
    run_random(200);
    write_table_base('0);
    run_random(150);
    write_table_base('1);
    run_random(150);
    write_table_base(wrap_base);
    run_random(400);

    // Drain the remaining results, then allow a few more cycles for stray strobes.
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (16) @(posedge clk);
    if (error_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
